>>> rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// shared widths and constants for the rotation matrix to quaternion block
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int FIELD_W = 16;            // matrix entries and quaternion parts
  localparam int ONE_Q14 = 16384;
  localparam int CAND_W  = 17;            // clamped candidate, unsigned
  localparam int RAD_W   = 30;            // candidate * 4096, even width for sqrt
  localparam int MAG_W   = RAD_W / 2;     // component magnitude
  localparam int SQ_W    = 2 * MAG_W;     // squared magnitude
  localparam int N2_W    = 32;            // sum of squares, even width for sqrt
  localparam int NORM_W  = N2_W / 2;      // norm
  localparam int NUM_W   = 30;            // rounded dividend
  localparam int QUO_W   = 15;            // quotient magnitude
  localparam int LANES   = 4;             // w, x, y, z

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [CAND_W-1:0]  cand_t;
  typedef logic [MAG_W-1:0]   mag_t;

endpackage

`default_nettype wire

>>> rtl/rmq_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// pipelined integer square root, one root bit per stage, several lanes
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_pipe #(
  parameter int W     = rmq_pkg::RAD_W,
  parameter int LANES = rmq_pkg::LANES,
  parameter int SW    = rmq_pkg::LANES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [LANES-1:0][W-1:0]     in_rad,
  input  wire logic [SW-1:0]               in_side,
  output logic                             out_valid,
  output logic [LANES-1:0][W/2-1:0]        out_root,
  output logic [SW-1:0]                    out_side
);
  import rmq_pkg::*;

  localparam int RW = W / 2;
  localparam int MW = RW + 3;

  logic                          vld_r  [RW];
  logic [LANES-1:0][MW-1:0]      rem_r  [RW];
  logic [LANES-1:0][RW-1:0]      root_r [RW];
  logic [LANES-1:0][W-1:0]       x_r    [RW];
  logic [SW-1:0]                 side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic                     p_vld;
    logic [LANES-1:0][MW-1:0] p_rem;
    logic [LANES-1:0][RW-1:0] p_root;
    logic [LANES-1:0][W-1:0]  p_x;
    logic [SW-1:0]            p_side;
    logic [LANES-1:0][MW-1:0] rem_nxt;
    logic [LANES-1:0][RW-1:0] root_nxt;
    logic [LANES-1:0][W-1:0]  x_nxt;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_x    = in_rad;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_x    = x_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      logic [MW-1:0] sh;
      logic [MW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        sh    = {p_rem[l][MW-3:0], p_x[l][W-1:W-2]};
        trial = {1'b0, p_root[l], 2'b01};
        if (sh >= trial) begin
          rem_nxt[l]  = sh - trial;
          root_nxt[l] = {p_root[l][RW-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = sh;
          root_nxt[l] = {p_root[l][RW-2:0], 1'b0};
        end
        x_nxt[l] = {p_x[l][W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      x_r[k]    <= x_nxt;
      side_r[k] <= p_side;
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

`default_nettype wire

>>> rtl/rmq_div_pipe.sv
// ----------------------------------------------------------------------------
// rmq_div_pipe
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_pipe #(
  parameter int NW    = rmq_pkg::NUM_W,
  parameter int DW    = rmq_pkg::NORM_W,
  parameter int QW    = rmq_pkg::QUO_W,
  parameter int LANES = rmq_pkg::LANES,
  parameter int SW    = rmq_pkg::LANES
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [LANES-1:0][NW-1:0]  in_num,
  input  wire logic [DW-1:0]             in_den,
  input  wire logic [SW-1:0]             in_side,
  output logic                           out_valid,
  output logic [LANES-1:0][QW-1:0]       out_quo,
  output logic [SW-1:0]                  out_side
);
  import rmq_pkg::*;

  localparam int RMW = DW + 1;

  logic                          vld_r  [QW];
  logic [LANES-1:0][RMW-1:0]     rem_r  [QW];
  logic [LANES-1:0][QW-1:0]      quo_r  [QW];
  logic [LANES-1:0][QW-1:0]      x_r    [QW];
  logic [DW-1:0]                 den_r  [QW];
  logic [SW-1:0]                 side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                      p_vld;
    logic [LANES-1:0][RMW-1:0] p_rem;
    logic [LANES-1:0][QW-1:0]  p_quo;
    logic [LANES-1:0][QW-1:0]  p_x;
    logic [DW-1:0]             p_den;
    logic [SW-1:0]             p_side;
    logic [LANES-1:0][RMW-1:0] rem_nxt;
    logic [LANES-1:0][QW-1:0]  quo_nxt;
    logic [LANES-1:0][QW-1:0]  x_nxt;

    if (k == 0) begin : g_first
      // upper dividend bits are known to be below the divisor
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          p_rem[l] = RMW'(in_num[l][NW-1:QW]);
          p_x[l]   = in_num[l][QW-1:0];
        end
      end
      assign p_vld  = in_valid;
      assign p_quo  = '0;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_quo  = quo_r[k-1];
      assign p_x    = x_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_side = side_r[k-1];
    end

    always_comb begin
      logic [RMW-1:0] sh;
      for (int l = 0; l < LANES; l++) begin
        sh = {p_rem[l][DW-1:0], p_x[l][QW-1]};
        if (sh >= {1'b0, p_den}) begin
          rem_nxt[l] = sh - {1'b0, p_den};
          quo_nxt[l] = {p_quo[l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = sh;
          quo_nxt[l] = {p_quo[l][QW-2:0], 1'b0};
        end
        x_nxt[l] = {p_x[l][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      x_r[k]    <= x_nxt;
      den_r[k]  <= p_den;
      side_r[k] <= p_side;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 q2.14 rotation matrix to unit quaternion, fully pipelined
// ----------------------------------------------------------------------------
// stages: 2 setup stages, 15 root stages, 2 norm stages, 16 root stages,
//   1 dividend stage, 15 divide stages, 1 output register
// throughput: one word per cycle, busy is never raised, no stalls
// reset: synchronous active-low, clears the valid bits of every stage
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire rmq_pkg::field_t in_r11,
  input  wire rmq_pkg::field_t in_r12,
  input  wire rmq_pkg::field_t in_r13,
  input  wire rmq_pkg::field_t in_r21,
  input  wire rmq_pkg::field_t in_r22,
  input  wire rmq_pkg::field_t in_r23,
  input  wire rmq_pkg::field_t in_r31,
  input  wire rmq_pkg::field_t in_r32,
  input  wire rmq_pkg::field_t in_r33,
  output logic                out_valid,
  output rmq_pkg::field_t     out_quat_w,
  output rmq_pkg::field_t     out_quat_x,
  output rmq_pkg::field_t     out_quat_y,
  output rmq_pkg::field_t     out_quat_z
);
  import rmq_pkg::*;

  localparam int TW = 18;   // signed candidate width
  localparam int DFW = 17;  // signed sign-source width
  localparam int LATENCY = 52;

  // pipeline never holds off a word
  assign busy = 1'b0;

  // ---- stage a: candidates, clamp, sign-source polarities ----
  logic                  a_vld_r;
  cand_t                 a_t_r [LANES];
  logic [5:0]            a_neg_r;
  cand_t                 a_t_nxt [LANES];
  logic [5:0]            a_neg_nxt;

  always_comb begin
    logic signed [TW-1:0]  e11, e22, e33, one;
    logic signed [TW-1:0]  t [LANES];
    logic signed [DFW-1:0] d [6];
    e11 = TW'(signed'(in_r11));
    e22 = TW'(signed'(in_r22));
    e33 = TW'(signed'(in_r33));
    one = TW'(ONE_Q14);
    t[0] =  e11 + e22 + e33 + one;
    t[1] =  e11 - e22 - e33 + one;
    t[2] = -e11 + e22 - e33 + one;
    t[3] = -e11 - e22 + e33 + one;
    for (int i = 0; i < LANES; i++) begin
      a_t_nxt[i] = t[i][TW-1] ? '0 : t[i][CAND_W-1:0];
    end
    // sign sources at full width
    d[0] = DFW'(signed'(in_r32)) - DFW'(signed'(in_r23));
    d[1] = DFW'(signed'(in_r13)) - DFW'(signed'(in_r31));
    d[2] = DFW'(signed'(in_r21)) - DFW'(signed'(in_r12));
    d[3] = DFW'(signed'(in_r21)) + DFW'(signed'(in_r12));
    d[4] = DFW'(signed'(in_r13)) + DFW'(signed'(in_r31));
    d[5] = DFW'(signed'(in_r32)) + DFW'(signed'(in_r23));
    for (int j = 0; j < 6; j++) begin
      a_neg_nxt[j] = d[j][DFW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    a_t_r   <= a_t_nxt;
    a_neg_r <= a_neg_nxt;
  end

  // ---- stage b: pick largest, resolve signs, form radicands ----
  localparam logic [1:0] BIG_W = 2'd0;
  localparam logic [1:0] BIG_X = 2'd1;
  localparam logic [1:0] BIG_Y = 2'd2;
  localparam logic [1:0] BIG_Z = 2'd3;

  logic                          b_vld_r;
  logic [LANES-1:0][RAD_W-1:0]   b_rad_r;
  logic [LANES-1:0]              b_neg_r;
  logic [LANES-1:0][RAD_W-1:0]   b_rad_nxt;
  logic [LANES-1:0]              b_neg_nxt;

  always_comb begin
    logic [1:0] big;
    cand_t      best;
    big  = BIG_W;
    best = a_t_r[0];
    // first one wins on a tie
    for (int i = 1; i < LANES; i++) begin
      if (a_t_r[i] > best) begin
        big  = 2'(i);
        best = a_t_r[i];
      end
    end
    b_neg_nxt = '0;
    case (big)
      BIG_W: begin
        b_neg_nxt[1] = a_neg_r[0];
        b_neg_nxt[2] = a_neg_r[1];
        b_neg_nxt[3] = a_neg_r[2];
      end
      BIG_X: begin
        b_neg_nxt[0] = a_neg_r[0];
        b_neg_nxt[2] = a_neg_r[3];
        b_neg_nxt[3] = a_neg_r[4];
      end
      BIG_Y: begin
        b_neg_nxt[0] = a_neg_r[1];
        b_neg_nxt[1] = a_neg_r[3];
        b_neg_nxt[3] = a_neg_r[5];
      end
      BIG_Z: begin
        b_neg_nxt[0] = a_neg_r[2];
        b_neg_nxt[1] = a_neg_r[4];
        b_neg_nxt[2] = a_neg_r[5];
      end
      default: b_neg_nxt = '0;
    endcase
    for (int i = 0; i < LANES; i++) begin
      b_rad_nxt[i] = {1'b0, a_t_r[i], 12'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_rad_r <= b_rad_nxt;
    b_neg_r <= b_neg_nxt;
  end

  // ---- component magnitudes ----
  logic                        s_vld;
  logic [LANES-1:0][MAG_W-1:0] s_mag;
  logic [LANES-1:0]            s_neg;

  rmq_sqrt_pipe #(
    .W     (RAD_W),
    .LANES (LANES),
    .SW    (LANES)
  ) u_mag_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_vld_r),
    .in_rad    (b_rad_r),
    .in_side   (b_neg_r),
    .out_valid (s_vld),
    .out_root  (s_mag),
    .out_side  (s_neg)
  );

  // ---- stage c: squares ----
  logic                        c_vld_r;
  logic [LANES-1:0][SQ_W-1:0]  c_sq_r;
  logic [LANES-1:0][MAG_W-1:0] c_mag_r;
  logic [LANES-1:0]            c_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      c_sq_r[i] <= s_mag[i] * s_mag[i];
    end
    c_mag_r <= s_mag;
    c_neg_r <= s_neg;
  end

  // ---- stage d: sum of squares ----
  localparam int SIDE_W = LANES * MAG_W + LANES;

  logic                        d_vld_r;
  logic [N2_W-1:0]             d_n2_r;
  logic [SIDE_W-1:0]           d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_n2_r   <= N2_W'(c_sq_r[0]) + N2_W'(c_sq_r[1]) + N2_W'(c_sq_r[2]) + N2_W'(c_sq_r[3]);
    d_side_r <= {c_mag_r, c_neg_r};
  end

  // ---- norm ----
  logic                        n_vld;
  logic [0:0][NORM_W-1:0]      n_norm;
  logic [SIDE_W-1:0]           n_side;

  rmq_sqrt_pipe #(
    .W     (N2_W),
    .LANES (1),
    .SW    (SIDE_W)
  ) u_norm_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_vld_r),
    .in_rad    (d_n2_r),
    .in_side   (d_side_r),
    .out_valid (n_vld),
    .out_root  (n_norm),
    .out_side  (n_side)
  );

  // ---- stage e: rounded dividends ----
  logic                        e_vld_r;
  logic [LANES-1:0][NUM_W-1:0] e_num_r;
  logic [NORM_W-1:0]           e_den_r;
  logic [LANES-1:0]            e_neg_r;
  logic [LANES-1:0][MAG_W-1:0] n_mag;
  logic [LANES-1:0]            n_neg;

  assign {n_mag, n_neg} = n_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      e_num_r[i] <= {1'b0, n_mag[i], 14'b0} + NUM_W'(n_norm[0][NORM_W-1:1]);
    end
    e_den_r <= n_norm[0];
    e_neg_r <= n_neg;
  end

  // ---- normalize ----
  logic                        q_vld;
  logic [LANES-1:0][QUO_W-1:0] q_mag;
  logic [LANES-1:0]            q_neg;

  rmq_div_pipe #(
    .NW    (NUM_W),
    .DW    (NORM_W),
    .QW    (QUO_W),
    .LANES (LANES),
    .SW    (LANES)
  ) u_norm_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_vld_r),
    .in_num    (e_num_r),
    .in_den    (e_den_r),
    .in_side   (e_neg_r),
    .out_valid (q_vld),
    .out_quo   (q_mag),
    .out_side  (q_neg)
  );

  // ---- output register: apply signs ----
  logic   o_vld_r;
  field_t o_q_r   [LANES];
  field_t o_q_nxt [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      o_q_nxt[i] = q_neg[i] ? -FIELD_W'(q_mag[i]) : FIELD_W'(q_mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    o_q_r <= o_q_nxt;
  end

  assign out_valid  = o_vld_r;
  assign out_quat_w = o_q_r[0];
  assign out_quat_x = o_q_r[1];
  assign out_quat_y = o_q_r[2];
  assign out_quat_z = o_q_r[3];

  // ---- checks ----
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching accepted word");

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_quat_w) <= 16384 && $signed(out_quat_w) >= -16384))
    else $error("quat_w out of range");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_quat_x) <= 16384 && $signed(out_quat_x) >= -16384))
    else $error("quat_x out of range");

endmodule

`default_nettype wire
